// ===== hw/rtl/acad_pkg.sv =====
// Shared types and constants for the chunk ADPCM decoder.
// Used by the front parser, the job queue, the sample engine and the top level.
package acad_pkg;

  // Kinds of work that the parser hands to the sample engine.
  typedef enum logic [2:0] {
    JOB_HDR = 3'd0,  // header done: new output size, id flag, level back to mid
    JOB_RAW = 3'd1,  // stored chunk byte, copied as is
    JOB_BIG = 3'd2,  // 5-bit signed delta without clipping
    JOB_REP = 3'd3,  // repeat the running level count+1 times
    JOB_D2  = 3'd4,  // data byte with four 2-bit deltas
    JOB_D4  = 3'd5,  // data byte with two 4-bit deltas
    JOB_LIT = 3'd6   // literal level byte
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] arg;    // data byte, repeat count or output size
    logic        id_ok;  // only meaningful for JOB_HDR
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // Command modes in the top two bits of a command byte.
  localparam logic [1:0] MODE_D2  = 2'd0;
  localparam logic [1:0] MODE_D4  = 2'd1;
  localparam logic [1:0] MODE_LIT = 2'd2;
  localparam logic [1:0] MODE_REP = 2'd3;

  localparam logic [31:0] CHUNK_ID    = 32'h0000_DEAF;
  localparam logic [15:0] LEVEL_MID   = 16'd128;
  localparam logic [7:0]  SAMPLE_FLIP = 8'h80;

  function automatic logic signed [4:0] delta2(input logic [1:0] code);
    logic signed [4:0] d;
    case (code)
      2'd0:    d = -5'sd2;
      2'd1:    d = -5'sd1;
      2'd2:    d = 5'sd0;
      default: d = 5'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [4:0] delta4(input logic [3:0] code);
    logic signed [4:0] d;
    case (code)
      4'd0:    d = -5'sd9;
      4'd1:    d = -5'sd8;
      4'd2:    d = -5'sd6;
      4'd3:    d = -5'sd5;
      4'd4:    d = -5'sd4;
      4'd5:    d = -5'sd3;
      4'd6:    d = -5'sd2;
      4'd7:    d = -5'sd1;
      4'd8:    d = 5'sd0;
      4'd9:    d = 5'sd1;
      4'd10:   d = 5'sd2;
      4'd11:   d = 5'sd3;
      4'd12:   d = 5'sd4;
      4'd13:   d = 5'sd5;
      4'd14:   d = 5'sd6;
      default: d = 5'sd8;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/acad_front.sv =====
// Byte parser: walks chunk headers and payloads and turns bytes into jobs.
// Depends on acad_pkg; feeds acad_queue.
module acad_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tready,
  input  logic [7:0]     in_byte,
  output logic           push,
  output acad_pkg::job_t push_job
);
  import acad_pkg::*;

  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic [15:0] pay_left_r, pay_left_nxt;
  logic [15:0] out_size_r, out_size_nxt;
  logic        raw_r, raw_nxt;
  logic        id_ok_r, id_ok_nxt;
  logic [1:0]  pend_mode_r, pend_mode_nxt;
  logic [6:0]  pend_cnt_r, pend_cnt_nxt;
  logic        in_pay_r, in_pay_nxt;
  logic        accept;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    hdr_pos_nxt   = hdr_pos_r;
    pay_left_nxt  = pay_left_r;
    out_size_nxt  = out_size_r;
    raw_nxt       = raw_r;
    id_ok_nxt     = id_ok_r;
    pend_mode_nxt = pend_mode_r;
    pend_cnt_nxt  = pend_cnt_r;
    in_pay_nxt    = in_pay_r;
    push          = 1'b0;
    push_job      = '{kind: JOB_RAW, arg: {8'h00, in_byte}, id_ok: 1'b0};
    if (accept) begin
      if (!in_pay_r) begin
        case (hdr_pos_r)
          3'd0:    pay_left_nxt = {8'h00, in_byte};
          3'd1:    pay_left_nxt = {in_byte, pay_left_r[7:0]};
          3'd2:    out_size_nxt = {8'h00, in_byte};
          3'd3:    out_size_nxt = {in_byte, out_size_r[7:0]};
          3'd4:    id_ok_nxt = (in_byte == CHUNK_ID[7:0]);
          3'd5:    id_ok_nxt = id_ok_r && (in_byte == CHUNK_ID[15:8]);
          3'd6:    id_ok_nxt = id_ok_r && (in_byte == CHUNK_ID[23:16]);
          default: id_ok_nxt = id_ok_r && (in_byte == CHUNK_ID[31:24]);
        endcase
        hdr_pos_nxt = hdr_pos_r + 3'd1;
        if (hdr_pos_r == 3'd7) begin
          raw_nxt      = (pay_left_r == out_size_r);
          pend_mode_nxt = MODE_D2;
          pend_cnt_nxt = 7'd0;
          in_pay_nxt   = (pay_left_r != 16'd0);
          push         = 1'b1;
          push_job     = '{kind: JOB_HDR, arg: out_size_r, id_ok: id_ok_nxt};
        end
      end else begin
        pay_left_nxt = pay_left_r - 16'd1;
        if (raw_r) begin
          push = 1'b1;
        end else if (pend_cnt_r == 7'd0) begin
          // Command byte: a big delta or a repeat runs at once, the rest
          // announce data bytes.
          if (in_byte[7:6] == MODE_LIT && in_byte[5]) begin
            push          = 1'b1;
            push_job.kind = JOB_BIG;
          end else if (in_byte[7:6] == MODE_REP) begin
            push          = 1'b1;
            push_job.kind = JOB_REP;
            push_job.arg  = {10'd0, in_byte[5:0]};
          end else begin
            pend_mode_nxt = in_byte[7:6];
            pend_cnt_nxt  = {1'b0, in_byte[5:0]} + 7'd1;
          end
        end else begin
          pend_cnt_nxt = pend_cnt_r - 7'd1;
          push         = 1'b1;
          case (pend_mode_r)
            MODE_D2: push_job.kind = JOB_D2;
            MODE_D4: push_job.kind = JOB_D4;
            default: push_job.kind = JOB_LIT;
          endcase
        end
        // Any data still announced is dropped when the payload runs out.
        if (pay_left_r == 16'd1) begin
          in_pay_nxt   = 1'b0;
          pend_cnt_nxt = 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= 3'd0;
      pay_left_r  <= 16'd0;
      out_size_r  <= 16'd0;
      raw_r       <= 1'b0;
      id_ok_r     <= 1'b1;
      pend_mode_r <= MODE_D2;
      pend_cnt_r  <= 7'd0;
      in_pay_r    <= 1'b0;
    end else begin
      hdr_pos_r   <= hdr_pos_nxt;
      pay_left_r  <= pay_left_nxt;
      out_size_r  <= out_size_nxt;
      raw_r       <= raw_nxt;
      id_ok_r     <= id_ok_nxt;
      pend_mode_r <= pend_mode_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      in_pay_r    <= in_pay_nxt;
    end
  end

endmodule

// ===== hw/rtl/acad_queue.sv =====
// Small job queue between the parser and the sample engine.
// Depends on acad_pkg for the job type.
module acad_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  acad_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output acad_pkg::job_t head_job
);
  import acad_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == DEPTH_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/acad_back.sv =====
// Sample engine: runs one job at a time into an output register, one sample
// step per cycle while not stalled. Depends on acad_pkg; takes jobs from acad_queue.
module acad_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  acad_pkg::job_t head_job,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_sample,
  output logic           out_last,
  output logic           out_chunk_end,
  output logic           out_bad_id
);
  import acad_pkg::*;

  logic [15:0] level_r, level_nxt;
  logic [15:0] left_r, left_nxt;
  logic        id_r, id_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] sample_r, sample_nxt;
  logic        last_r, last_nxt;
  logic        cend_r, cend_nxt;
  logic        bad_r, bad_nxt;

  logic              adv, run, final_step, emits;
  logic signed [4:0] delta;
  logic signed [16:0] sum;
  logic [7:0]        s8;
  logic [7:0]        shifted;

  assign adv = !valid_r || out_tready;
  assign run = adv && head_valid;

  always_comb begin
    case (head_job.kind)
      JOB_D2:  final_step = (step_r == 6'd3);
      JOB_D4:  final_step = (step_r == 6'd1);
      JOB_REP: final_step = (step_r == head_job.arg[5:0]);
      default: final_step = 1'b1;
    endcase
  end

  assign pop = run && final_step;

  always_comb begin
    shifted = 8'h00;
    delta   = 5'sd0;
    case (head_job.kind)
      JOB_D2: begin
        shifted = head_job.arg[7:0] >> {step_r[1:0], 1'b0};
        delta   = delta2(shifted[1:0]);
      end
      JOB_D4: begin
        shifted = head_job.arg[7:0] >> {step_r[0], 2'b00};
        delta   = delta4(shifted[3:0]);
      end
      JOB_BIG: delta = head_job.arg[4:0];
      default: delta = 5'sd0;
    endcase
    sum = {level_r[15], level_r} + 17'(delta);
  end

  always_comb begin
    level_nxt  = level_r;
    left_nxt   = left_r;
    id_nxt     = id_r;
    step_nxt   = step_r;
    valid_nxt  = valid_r && !out_tready;
    sample_nxt = sample_r;
    last_nxt   = last_r;
    cend_nxt   = cend_r;
    bad_nxt    = bad_r;
    s8         = level_r[7:0];
    emits      = 1'b0;
    if (run) begin
      step_nxt = final_step ? 6'd0 : step_r + 6'd1;
      emits    = (head_job.kind != JOB_HDR) && (left_r != 16'd0);
      case (head_job.kind)
        JOB_HDR: begin
          level_nxt = LEVEL_MID;
          left_nxt  = head_job.arg;
          id_nxt    = head_job.id_ok;
        end
        JOB_RAW: s8 = head_job.arg[7:0];
        JOB_BIG: begin
          level_nxt = sum[15:0];
          s8        = sum[7:0];
        end
        JOB_LIT: begin
          level_nxt = {8'h00, head_job.arg[7:0]};
          s8        = head_job.arg[7:0];
        end
        JOB_D2, JOB_D4: begin
          // Table deltas clip the signed level to the byte range.
          if (sum[16]) begin
            level_nxt = 16'd0;
          end else if (sum[15:8] != 8'h00) begin
            level_nxt = 16'd255;
          end else begin
            level_nxt = sum[15:0];
          end
          s8 = level_nxt[7:0];
        end
        default: s8 = level_r[7:0];
      endcase
      if (emits) begin
        left_nxt   = left_r - 16'd1;
        valid_nxt  = 1'b1;
        sample_nxt = id_r ? {s8 ^ SAMPLE_FLIP, 8'h00} : 16'h0000;
        cend_nxt   = (left_r == 16'd1);
        last_nxt   = final_step || (left_r == 16'd1);
        bad_nxt    = !id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_MID;
      left_r  <= 16'd0;
      id_r    <= 1'b1;
      step_r  <= 6'd0;
      valid_r <= 1'b0;
    end else begin
      level_r <= level_nxt;
      left_r  <= left_nxt;
      id_r    <= id_nxt;
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    cend_r   <= cend_nxt;
    bad_r    <= bad_nxt;
  end

  assign out_tvalid    = valid_r;
  assign out_sample    = sample_r;
  assign out_last      = last_r;
  assign out_chunk_end = cend_r;
  assign out_bad_id    = bad_r;

endmodule

// ===== hw/rtl/aud_chunk_adpcm_decoder_core.sv =====
// Chunk ADPCM decoder: takes a chunk byte stream and returns 16-bit samples.
// Depends on acad_pkg, acad_front, acad_queue and acad_back.
//
// Each chunk is an 8-byte little-endian header (payload size, output size,
// id word 0x0000DEAF) and its payload. The parser takes one byte per cycle
// while its job queue has room; header bytes and command bytes that only
// announce data give no sample. The sample engine makes one sample per
// cycle while its output is not stalled, so a 2-bit delta byte gives four
// samples, a 4-bit delta byte two, a repeat command count+1 (up to 64), and
// any other payload byte one. Samples past the chunk's output size are dropped,
// and a chunk with a wrong id gives zero samples flagged as bad. out_tlast
// marks the last sample caused by one input byte. No clearing pass is needed
// after reset.
module aud_chunk_adpcm_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] pcm_sample
  output logic        out_tlast,  // last_of_run
  output logic [1:0]  out_tuser   // [0] chunk_end, [1] bad_id
);
  import acad_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_push_job, q_head_job;

  assign in_tready = !q_full;

  acad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .push      (q_push),
    .push_job  (q_push_job)
  );

  acad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  acad_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (q_head_valid),
    .head_job      (q_head_job),
    .pop           (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_sample    (out_tdata),
    .out_last      (out_tlast),
    .out_chunk_end (out_tuser[0]),
    .out_bad_id    (out_tuser[1])
  );

  // The sample that fills the output size always closes its byte's run.
  a_cend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("chunk end without last of run");

  // A chunk with a wrong id never leaks decoded data.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 16'h0000)
    else $error("bad id sample is not zero");

  // The parser only pushes when it is allowed to take a byte.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_tvalid && !q_full)
    else $error("job pushed into a full queue");

  // Jobs are only retired while the output register can take a sample.
  a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid && (!out_tvalid || out_tready))
    else $error("job retired while output stalled");

endmodule

// ===== tb/tb_aud_chunk_adpcm_decoder_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for aud_chunk_adpcm_decoder_core: a directed chunk table,
// then random chunk streams with and without sender and receiver idling. Depends on acad_pkg.
module tb_aud_chunk_adpcm_decoder_core;
  import acad_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 45;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        ce;
    logic        bad;
  } pcm_result_t;

  // One stream byte; when known is set, its results are typed in by hand.
  typedef struct packed {
    logic [7:0]  data;
    logic        known;
    logic [6:0]  n;
    logic [15:0] sample;
    logic        ce;
    logic        bad;
  } chunk_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  chunk_byte_t in_row;

  pcm_result_t expected_pcm[$];
  chunk_byte_t byte_stream[$];

  int gap_pct;
  int stall_pct;
  int sent_cnt;
  int err_cnt;
  int idle_cyc;

  // Decoder state mirrored by the prediction tasks.
  logic [2:0]  hdr_pos;
  logic [15:0] pay_left;
  logic [15:0] out_left;
  logic        raw_chunk;
  logic        id_ok;
  logic        in_pay;
  logic [15:0] level;
  logic [1:0]  run_mode;
  logic [6:0]  run_left;
  pcm_result_t held;
  logic        holding;

  int          base_n;
  pcm_result_t want;

  aud_chunk_adpcm_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic int two_bit_step(input logic [1:0] code);
    case (code)
      2'd0:    return -2;
      2'd1:    return -1;
      2'd2:    return 0;
      default: return 1;
    endcase
  endfunction

  function automatic int four_bit_step(input logic [3:0] code);
    case (code)
      4'd0:    return -9;
      4'd1:    return -8;
      4'd2:    return -6;
      4'd3:    return -5;
      4'd4:    return -4;
      4'd5:    return -3;
      4'd6:    return -2;
      4'd7:    return -1;
      4'd8:    return 0;
      4'd9:    return 1;
      4'd10:   return 2;
      4'd11:   return 3;
      4'd12:   return 4;
      4'd13:   return 5;
      4'd14:   return 6;
      default: return 8;
    endcase
  endfunction

  // The newest sample is held back so that the last one of a byte can be marked.
  task automatic put_sample(input logic [7:0] s);
    pcm_result_t r;
    if (out_left != 16'd0) begin
      out_left = out_left - 16'd1;
      r.sample = id_ok ? {s ^ SAMPLE_FLIP, 8'h00} : 16'h0000;
      r.last   = 1'b0;
      r.ce     = (out_left == 16'd0);
      r.bad    = !id_ok;
      if (holding) expected_pcm.push_back(held);
      held    = r;
      holding = 1'b1;
    end
  endtask

  task automatic clip_step(input int d);
    int v;
    v = $signed(level) + d;
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    level = v[15:0];
    put_sample(v[7:0]);
  endtask

  task automatic take_header(input logic [7:0] b);
    logic [31:0] id_word;
    case (hdr_pos)
      3'd0: pay_left = {8'h00, b};
      3'd1: pay_left[15:8] = b;
      3'd2: out_left = {8'h00, b};
      3'd3: out_left[15:8] = b;
      3'd4: id_ok = (b == CHUNK_ID[7:0]);
      default: begin
        id_word = CHUNK_ID >> (8 * (hdr_pos - 3'd4));
        id_ok = id_ok && (b == id_word[7:0]);
      end
    endcase
    if (hdr_pos == 3'd7) begin
      raw_chunk = (pay_left == out_left);
      level     = LEVEL_MID;
      run_mode  = MODE_D2;
      run_left  = 7'd0;
      in_pay    = (pay_left != 16'd0);
    end
    hdr_pos = hdr_pos + 3'd1;
  endtask

  task automatic take_command(input logic [7:0] b);
    logic [1:0] md;
    logic [5:0] cnt;
    md  = b[7:6];
    cnt = b[5:0];
    if (md == MODE_LIT && cnt[5]) begin
      // The big delta wraps the level at 16 bits with no clipping.
      level = level + {{11{cnt[4]}}, cnt[4:0]};
      put_sample(level[7:0]);
    end else if (md == MODE_REP) begin
      for (int k = 0; k <= cnt; k++) put_sample(level[7:0]);
    end else begin
      run_mode = md;
      run_left = cnt + 7'd1;
    end
  endtask

  task automatic take_data(input logic [7:0] b);
    run_left = run_left - 7'd1;
    case (run_mode)
      MODE_D2: for (int k = 0; k < 4; k++) clip_step(two_bit_step(b[2*k +: 2]));
      MODE_D4: begin
        clip_step(four_bit_step(b[3:0]));
        clip_step(four_bit_step(b[7:4]));
      end
      default: begin
        level = {8'h00, b};
        put_sample(b);
      end
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b);
    holding = 1'b0;
    if (!in_pay) begin
      take_header(b);
    end else begin
      pay_left = pay_left - 16'd1;
      if (raw_chunk) put_sample(b);
      else if (run_left == 7'd0) take_command(b);
      else take_data(b);
      // A run that is still open at the end of the payload is dropped.
      if (pay_left == 16'd0) begin
        in_pay   = 1'b0;
        run_left = 7'd0;
      end
    end
    if (holding) begin
      held.last = 1'b1;
      expected_pcm.push_back(held);
    end
  endtask

  function automatic chunk_byte_t byte_row(input logic [7:0] d);
    chunk_byte_t r;
    r      = '0;
    r.data = d;
    return r;
  endfunction

  function automatic chunk_byte_t known_row(input logic [7:0] d, input int n,
                                            input logic [15:0] s, input logic ce,
                                            input logic bad);
    chunk_byte_t r;
    r.data   = d;
    r.known  = 1'b1;
    r.n      = n[6:0];
    r.sample = s;
    r.ce     = ce;
    r.bad    = bad;
    return r;
  endfunction

  task automatic add_header(input int pay, input int outsz, input logic [31:0] id);
    logic [63:0] hdr;
    hdr = {id, outsz[15:0], pay[15:0]};
    for (int i = 0; i < 8; i++) begin
      byte_stream.push_back(known_row(hdr[8*i +: 8], 0, 16'h0000, 1'b0, 1'b0));
    end
  endtask

  task automatic build_chunk(input logic big);
    int          kind;
    int          pay;
    int          outsz;
    int          pend;
    int          r;
    int          pos;
    logic        drift;
    logic        neg;
    logic        raw;
    logic [31:0] id;
    logic [1:0]  md;
    logic [5:0]  cnt;
    logic [7:0]  b;
    kind  = $urandom_range(99);
    drift = 1'b0;
    raw   = 1'b0;
    neg   = 1'($urandom_range(1));
    id    = CHUNK_ID;
    if ($urandom_range(99) < 12) begin
      pos = $urandom_range(3);
      id[8*pos +: 8] = id[8*pos +: 8] ^ 8'($urandom_range(1, 255));
    end
    if (big) begin
      pay   = $urandom_range(256, 264);
      outsz = $urandom_range(0, 65535);
    end else if (kind < 8) begin
      pay   = 0;
      outsz = $urandom_range(0, 65535);
    end else if (kind < 28) begin
      pay   = $urandom_range(1, 20);
      outsz = pay;
      raw   = 1'b1;
    end else begin
      // Drift chunks push the level out of byte range with big deltas.
      drift = (kind >= 90);
      pay   = drift ? 20 : $urandom_range(1, 24);
      case ($urandom_range(3))
        0:       outsz = $urandom_range(0, 8);
        1:       outsz = $urandom_range(256, 65535);
        default: outsz = $urandom_range(9, 80);
      endcase
    end
    add_header(pay, outsz, id);
    pend = 0;
    for (int i = 0; i < pay; i++) begin
      if (raw || $urandom_range(99) < 8) begin
        b = 8'($urandom_range(255));
      end else if (drift) begin
        if (i == pay - 2) b = 8'h00;
        else if (i == pay - 1) b = 8'($urandom_range(255));
        else b = neg ? 8'hB0 + 8'($urandom_range(7)) : 8'hA8 + 8'($urandom_range(7));
      end else if (pend == 0) begin
        md = 2'($urandom_range(3));
        r  = $urandom_range(99);
        if (r < 70) cnt = 6'($urandom_range(3));
        else if (r < 90) cnt = 6'($urandom_range(4, 15));
        else cnt = 6'($urandom_range(16, 63));
        if (md == MODE_LIT) cnt[5] = 1'($urandom_range(1));
        b = {md, cnt};
      end else begin
        b = 8'($urandom_range(255));
      end
      // Follow the command structure so that commands and data stay in step.
      if (!raw) begin
        if (pend > 0) pend--;
        else if (b[7:6] == MODE_REP || (b[7:6] == MODE_LIT && b[5])) pend = 0;
        else pend = b[5:0] + 1;
      end
      byte_stream.push_back(byte_row(b));
    end
  endtask

  task automatic send_byte(input chunk_byte_t s);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s.data;
    in_row    <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic play_stream();
    foreach (byte_stream[i]) send_byte(byte_stream[i]);
    byte_stream.delete();
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (expected_pcm.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // Input transfers are predicted before output transfers are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        base_n = expected_pcm.size();
        decode_byte(in_row.data);
        if (in_row.known) begin
          while (expected_pcm.size() > base_n) expected_pcm.delete(expected_pcm.size() - 1);
          for (int k = 0; k < in_row.n; k++) begin
            want.sample = in_row.sample;
            want.last   = (k == in_row.n - 1);
            want.ce     = in_row.ce && (k == in_row.n - 1);
            want.bad    = in_row.bad;
            expected_pcm.push_back(want);
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_pcm.size() == 0) begin
          $display("%0t: sample %h last %b flags %b with no expectation waiting",
                   $time, out_tdata, out_tlast, out_tuser);
          err_cnt++;
        end else begin
          want = expected_pcm.pop_front();
          check_field("pcm_sample", want.sample, out_tdata);
          check_field("last_of_run", 16'(want.last), 16'(out_tlast));
          check_field("chunk_end", 16'(want.ce), 16'(out_tuser[0]));
          check_field("bad_id", 16'(want.bad), 16'(out_tuser[1]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cyc);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    int goal;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_row     = '0;
    out_tready = 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    sent_cnt   = 0;
    err_cnt    = 0;
    idle_cyc   = 0;
    hdr_pos    = 3'd0;
    pay_left   = 16'd0;
    out_left   = 16'd0;
    raw_chunk  = 1'b0;
    id_ok      = 1'b1;
    in_pay     = 1'b0;
    level      = LEVEL_MID;
    run_mode   = MODE_D2;
    run_left   = 7'd0;
    holding    = 1'b0;
    held       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Good chunk, output size never reached: big deltas, then the 2-bit, 4-bit and literal modes.
    add_header(9, 64, CHUNK_ID);
    byte_stream.push_back(byte_row(8'hBF));                               // big delta of -1
    byte_stream.push_back(byte_row(8'hAF));                               // big delta of +15
    byte_stream.push_back(known_row(8'h00, 0, 16'h0000, 1'b0, 1'b0));     // one 2-bit data byte
    byte_stream.push_back(byte_row(8'h00));
    byte_stream.push_back(known_row(8'h41, 0, 16'h0000, 1'b0, 1'b0));     // two 4-bit data bytes
    byte_stream.push_back(byte_row(8'hFF));
    byte_stream.push_back(byte_row(8'h00));
    byte_stream.push_back(known_row(8'h80, 0, 16'h0000, 1'b0, 1'b0));     // one literal
    byte_stream.push_back(known_row(8'hFF, 1, 16'h7F00, 1'b0, 1'b0));
    // Bad id, output size 1: a 64-long repeat gives one zero sample, and the
    // run opened by the last byte crosses the end of the payload.
    add_header(2, 1, 32'h0001_DEAF);
    byte_stream.push_back(known_row(8'hFF, 1, 16'h0000, 1'b1, 1'b1));
    byte_stream.push_back(known_row(8'h00, 0, 16'h0000, 1'b0, 1'b0));
    play_stream();
    wait_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 71; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 37; stall_pct = 37; end
      endcase
      goal = sent_cnt + PHASE_ITEMS;
      if (ph == 1) begin
        build_chunk(1'b1);
        play_stream();
      end
      while (sent_cnt < goal) begin
        build_chunk(1'b0);
        play_stream();
      end
      wait_results();
    end

    stall_pct = 0;
    wait_results();
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && expected_pcm.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/acad_pkg.sv
hw/rtl/acad_front.sv
hw/rtl/acad_queue.sv
hw/rtl/acad_back.sv
hw/rtl/aud_chunk_adpcm_decoder_core.sv
tb/tb_aud_chunk_adpcm_decoder_core.sv
